@@ rtl/core/upe_pkg.sv @@
// Shared types and constants for the URL percent encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package upe_pkg;

    localparam int CHAR_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int MAX_BYTES = 9;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_INPUT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPERCASE_HEX = 8'd1;

    // encoded output of one character: bytes in emission order
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]                 count;
    } enc_seq_t;

endpackage

`default_nettype wire

@@ rtl/core/url_percent_encoder_core.sv @@
// Top level of the URL percent encoder: input register, config registers,
// encoder and output byte buffer. Depends on upe_pkg, upe_encoder, upe_serializer.
//
// Usage:
//   s_* carries one character code per transfer (16 bits; low 8 used in narrow
//   mode). A code of zero ends a string and produces nothing.
//   m_* carries encoded ASCII bytes, one per transfer; m_tlast marks the final
//   byte produced by an input character.
//   cfg_* writes the mode registers (index 0 wide_input, 1 uppercase_hex);
//   always ready, write only while the block is idle.
// Data path: an input character passes the input register, then the byte buffer,
// which presents its bytes on m_*.
// Throughput: one character per cycle while each gives one byte and m_tready is
// high; a character that expands to 3, 6 or 9 bytes holds the buffer until all
// of them have left through the single output byte port.
// Reset: both mode registers go to 1, all pipeline contents are dropped.
// Stall: when m_tready is low the buffer holds; the input register keeps one
// more character and then s_tready drops.
`default_nettype none

module url_percent_encoder_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [upe_pkg::CHAR_W-1:0]     s_tdata,   // [15:0] char_code
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [upe_pkg::BYTE_W-1:0]          m_tdata,   // [7:0] out_char
    output logic                                m_tlast,   // last_of_item
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [upe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic                           cfg_data
);
    import upe_pkg::*;

    logic              wide_reg, upper_reg;
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_code_reg;
    enc_seq_t          seq;
    logic              can_load;
    logic              in_adv;
    logic              buf_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg  <= 1'b1;
            upper_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WIDE_INPUT:    wide_reg  <= cfg_data;
                REG_UPPERCASE_HEX: upper_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    upe_encoder u_enc (
        .char_code     (in_code_reg),
        .wide_input    (wide_reg),
        .uppercase_hex (upper_reg),
        .seq           (seq)
    );

    // end marks leave the input register without touching the buffer
    assign in_adv   = in_valid_reg && (seq.count == '0 || can_load);
    assign buf_load = in_adv && (seq.count != '0);
    assign s_tready = !in_valid_reg || in_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_code_reg <= s_tdata;
    end

    upe_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (buf_load),
        .seq      (seq),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/core/upe_encoder.sv @@
// Combinational encoder: one character code to its percent-encoded byte run.
// Depends on upe_pkg.
`default_nettype none

module upe_encoder (
    input  wire logic [upe_pkg::CHAR_W-1:0] char_code,
    input  wire logic                       wide_input,
    input  wire logic                       uppercase_hex,
    output upe_pkg::enc_seq_t               seq
);
    import upe_pkg::*;

    logic [CHAR_W-1:0]      c;
    logic                   is_pass;
    logic [2:0][BYTE_W-1:0] utf;
    logic [1:0]             nb;

    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib, input logic upper);
        logic [BYTE_W-1:0] base;
        base = upper ? 8'h41 : 8'h61;
        if (nib < 4'd10)
            hex_digit = 8'h30 + {4'd0, nib};
        else
            hex_digit = base + {4'd0, nib} - 8'd10;
    endfunction

    assign c = wide_input ? char_code : {8'd0, char_code[7:0]};

    assign is_pass = (c >= 16'h61 && c <= 16'h7a) || (c >= 16'h41 && c <= 16'h5a) ||
                     (c >= 16'h30 && c <= 16'h39) || c == 16'h2d || c == 16'h5f ||
                     c == 16'h2e;

    always_comb
    begin
        utf = '0;
        if (!wide_input || c < 16'h0080)
        begin
            nb     = 2'd1;
            utf[0] = c[7:0];
        end
        else if (c < 16'h0800)
        begin
            nb     = 2'd2;
            utf[0] = 8'hc0 | {3'd0, c[10:6]};
            utf[1] = 8'h80 | {2'd0, c[5:0]};
        end
        else
        begin
            nb     = 2'd3;
            utf[0] = 8'he0 | {4'd0, c[15:12]};
            utf[1] = 8'h80 | {2'd0, c[11:6]};
            utf[2] = 8'h80 | {2'd0, c[5:0]};
        end
    end

    always_comb
    begin
        seq = '0;
        if (c == '0)
        begin
            seq.count = '0;
        end
        else if (c == 16'h20)
        begin
            seq.bytes[0] = 8'h2b;
            seq.count    = 4'd1;
        end
        else if (is_pass)
        begin
            seq.bytes[0] = c[7:0];
            seq.count    = 4'd1;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                seq.bytes[3*i]   = 8'h25;
                seq.bytes[3*i+1] = hex_digit(utf[i][7:4], uppercase_hex);
                seq.bytes[3*i+2] = hex_digit(utf[i][3:0], uppercase_hex);
            end
            seq.count = (nb == 2'd1) ? 4'd3 : ((nb == 2'd2) ? 4'd6 : 4'd9);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/upe_serializer.sv @@
// Byte run buffer: holds one encoded run and sends it one byte per transfer.
// Depends on upe_pkg.
`default_nettype none

module upe_serializer (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      load,
    input  wire upe_pkg::enc_seq_t         seq,
    output logic                           can_load,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [upe_pkg::BYTE_W-1:0]     m_tdata,   // [7:0] out_char
    output logic                           m_tlast    // last_of_item
);
    import upe_pkg::*;

    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes_reg;
    logic [CNT_W-1:0]                 cnt_reg;
    logic [CNT_W-1:0]                 idx_reg, idx_next;
    logic                             valid_reg, valid_next;
    logic                             at_last;

    assign at_last  = (idx_reg == cnt_reg - 4'd1);
    assign can_load = !valid_reg || (m_tready && at_last);
    assign m_tvalid = valid_reg;
    assign m_tdata  = bytes_reg[idx_reg];
    assign m_tlast  = at_last;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (valid_reg && m_tready)
        begin
            if (at_last)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= seq.bytes;
            cnt_reg   <= seq.count;
        end
    end

endmodule

`default_nettype wire
